FILE: rtl/pwhd_pkg.sv
// Shared types, constants and helpers for the PID controller with hysteresis deadband.
// No dependencies; imported by every module of the block.
`default_nettype none

package pwhd_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int GAIN_W             = 16;
  localparam int LIMIT_W            = 31;
  localparam int THR_W              = 16;
  localparam int ACC_W              = 32;
  localparam int THR5_W             = THR_W + 3;
  localparam int KIND_W             = 2;
  localparam int CFG_ADDR_W         = 3;
  localparam int CFG_DATA_W         = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_RAISE  = 2'd2
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_INT_LIMIT  = 3'd3,
    REG_OUT_LIMIT  = 3'd4,
    REG_DB_THRESH  = 3'd5,
    REG_LOOP_EN    = 3'd6,
    REG_AUTO_CLEAR = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [LIMIT_W-1:0]       output_limit;
    logic [THR_W-1:0]         deadband_threshold;
    logic                     loop_enable;
    logic                     auto_clear;
  } pwhd_cfg_t;

  // Symmetric clamp to +-lim; lim of zero passes x through.
  function automatic logic signed [ACC_W-1:0] clamp_sym(
    input logic signed [ACC_W-1:0] x,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [ACC_W-1:0] pos;
    logic signed [ACC_W-1:0] neg;
    logic signed [ACC_W-1:0] res;
    pos = signed'({1'b0, lim});
    neg = -pos;
    res = x;
    if (lim != '0) begin
      if (x > pos) begin
        res = pos;
      end else if (x < neg) begin
        res = neg;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pwhd_state.sv
// Error, hysteresis deadband and integral update; owns the loop state registers.
// Depends on pwhd_pkg.
`default_nettype none

module pwhd_state #(
  parameter int SAMPLE_WIDTH = pwhd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               advance,
  input  wire pwhd_pkg::pwhd_cfg_t          cfg,
  input  wire pwhd_pkg::kind_t              kind,
  input  wire logic signed [SAMPLE_WIDTH-1:0] target,
  input  wire logic signed [SAMPLE_WIDTH-1:0] measured,
  input  wire logic signed [31:0]           preset_value,
  output logic                              st_compute,
  output logic signed [SAMPLE_WIDTH:0]      st_err,
  output logic signed [SAMPLE_WIDTH+1:0]    st_derr,
  output logic signed [31:0]                st_integral,
  output logic                              st_stable
);
  import pwhd_pkg::*;

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int DW = SAMPLE_WIDTH + 2;
  localparam int CW = ((EW > THR5_W) ? EW : THR5_W) + 1;
  localparam int AW = ((EW > ACC_W) ? EW : ACC_W) + 1;

  logic signed [ACC_W-1:0] integral_acc;
  logic signed [EW-1:0]    previous_error;
  logic                    stable_flag;

  logic signed [EW-1:0]    err;
  logic [EW-1:0]           mag;
  logic [THR5_W-1:0]       thr5;
  logic                    below_in;
  logic                    below_out;
  logic                    zero_err;
  logic                    clr;
  logic                    stable_calc;
  logic signed [EW-1:0]    e_eff;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [AW-1:0]    isum;
  logic                    ovf;
  logic signed [ACC_W-1:0] isat;
  logic signed [ACC_W-1:0] int_new;
  logic                    raise_ok;

  logic signed [ACC_W-1:0] integral_acc_next;
  logic signed [EW-1:0]    previous_error_next;
  logic                    stable_flag_next;
  logic                    compute_next;

  always_comb begin
    err = EW'(target) - EW'(measured);
    mag = err[EW-1] ? EW'(-err) : EW'(err);
    thr5 = THR5_W'({cfg.deadband_threshold, 2'b00}) + THR5_W'(cfg.deadband_threshold);
    below_in  = CW'(mag) < CW'(cfg.deadband_threshold);
    below_out = CW'(mag) < CW'(thr5);

    // hysteresis: enter below threshold, leave at five times threshold
    stable_calc = stable_flag;
    zero_err    = 1'b0;
    clr         = 1'b0;
    if (cfg.deadband_threshold != '0) begin
      if (stable_flag) begin
        if (below_out) begin
          zero_err = 1'b1;
          clr      = cfg.auto_clear;
        end else begin
          stable_calc = 1'b0;
        end
      end else if (below_in) begin
        zero_err    = 1'b1;
        stable_calc = 1'b1;
        clr         = cfg.auto_clear;
      end
    end

    e_eff    = zero_err ? '0 : err;
    acc_base = clr ? '0 : integral_acc;
    isum     = AW'(acc_base) + AW'(e_eff);
    ovf      = !((&isum[AW-1:ACC_W-1]) || !(|isum[AW-1:ACC_W-1]));
    isat     = ovf ? (isum[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : isum[ACC_W-1:0];
    int_new  = clamp_sym(isat, cfg.integral_limit);

    raise_ok = (!preset_value[31] && (preset_value != '0) && (integral_acc < preset_value)) ||
               (preset_value[31] && (integral_acc > preset_value));

    integral_acc_next   = integral_acc;
    previous_error_next = previous_error;
    stable_flag_next    = stable_flag;
    compute_next        = 1'b0;
    case (kind)
      KIND_SAMPLE: begin
        if (cfg.loop_enable) begin
          integral_acc_next   = int_new;
          previous_error_next = e_eff;
          stable_flag_next    = stable_calc;
          compute_next        = 1'b1;
        end
      end
      KIND_LOAD: begin
        integral_acc_next = preset_value;
      end
      KIND_RAISE: begin
        if (raise_ok) begin
          integral_acc_next = clamp_sym(preset_value, cfg.integral_limit);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc   <= '0;
      previous_error <= '0;
      stable_flag    <= 1'b0;
    end else if (advance) begin
      integral_acc   <= integral_acc_next;
      previous_error <= previous_error_next;
      stable_flag    <= stable_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_compute  <= compute_next;
      st_err      <= e_eff;
      st_derr     <= DW'(e_eff) - DW'(previous_error);
      st_integral <= integral_acc_next;
      st_stable   <= stable_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pwhd_mult.sv
// Registered gain products for the P, I and D terms.
// Depends on pwhd_pkg.
`default_nettype none

module pwhd_mult #(
  parameter int SAMPLE_WIDTH = pwhd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 advance,
  input  wire pwhd_pkg::pwhd_cfg_t            cfg,
  input  wire                                 st_compute,
  input  wire logic signed [SAMPLE_WIDTH:0]   st_err,
  input  wire logic signed [SAMPLE_WIDTH+1:0] st_derr,
  input  wire logic signed [31:0]             st_integral,
  input  wire                                 st_stable,
  output logic                                mu_compute,
  output logic signed [SAMPLE_WIDTH+16:0]     mu_p,
  output logic signed [47:0]                  mu_i,
  output logic signed [SAMPLE_WIDTH+17:0]     mu_d,
  output logic signed [31:0]                  mu_integral,
  output logic                                mu_stable
);
  import pwhd_pkg::*;

  localparam int PW = SAMPLE_WIDTH + 1 + GAIN_W;
  localparam int IW = ACC_W + GAIN_W;
  localparam int DPW = SAMPLE_WIDTH + 2 + GAIN_W;

  always_ff @(posedge clk) begin
    if (advance) begin
      mu_compute  <= st_compute;
      mu_p        <= PW'(st_err) * PW'(cfg.gain_p);
      mu_i        <= IW'(st_integral) * IW'(cfg.gain_i);
      mu_d        <= DPW'(st_derr) * DPW'(cfg.gain_d);
      mu_integral <= st_integral;
      mu_stable   <= st_stable;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pwhd_out.sv
// Product sum, Q8.8 scaling, saturation and output clamp; holds the drive and result register.
// Depends on pwhd_pkg.
`default_nettype none

module pwhd_out #(
  parameter int SAMPLE_WIDTH   = pwhd_pkg::SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pwhd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 advance,
  input  wire pwhd_pkg::pwhd_cfg_t            cfg,
  input  wire                                 mu_compute,
  input  wire logic signed [SAMPLE_WIDTH+16:0] mu_p,
  input  wire logic signed [47:0]             mu_i,
  input  wire logic signed [SAMPLE_WIDTH+17:0] mu_d,
  input  wire logic signed [31:0]             mu_integral,
  input  wire                                 mu_stable,
  output logic signed [31:0]                  held_drive,
  output logic signed [31:0]                  out_integral,
  output logic                                out_stable
);
  import pwhd_pkg::*;

  localparam int DPW  = SAMPLE_WIDTH + 2 + GAIN_W;
  localparam int IW   = ACC_W + GAIN_W;
  localparam int SUMW = ((DPW > IW) ? DPW : IW) + 2;

  logic signed [SUMW-1:0]  sum;
  logic signed [SUMW-1:0]  shifted;
  logic                    ovf;
  logic signed [ACC_W-1:0] dsat;
  logic signed [ACC_W-1:0] drive_new;

  always_comb begin
    sum       = SUMW'(mu_p) + SUMW'(mu_i) + SUMW'(mu_d);
    shifted   = sum >>> GAIN_FRAC_BITS;   // floor
    ovf       = !((&shifted[SUMW-1:ACC_W-1]) || !(|shifted[SUMW-1:ACC_W-1]));
    dsat      = ovf ? (shifted[SUMW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                    : shifted[ACC_W-1:0];
    drive_new = clamp_sym(dsat, cfg.output_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_drive <= '0;
    end else if (advance && mu_compute) begin
      held_drive <= drive_new;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_integral <= mu_integral;
      out_stable   <= mu_stable;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pid_with_hysteresis_deadband_top.sv
// Top level of the positional PID controller with hysteresis deadband and anti-windup.
// Depends on pwhd_pkg, pwhd_state, pwhd_mult and pwhd_out.
`default_nettype none

// Positional PID controller. Every input transfer yields exactly one output transfer,
// in order. Throughput is one item per clock while m_tready is high; each item
// passes through four register stages: input register, state update (error,
// deadband hysteresis, integral saturate/clamp), gain multipliers, then
// sum/shift/saturate/clamp into the output register. The integral and deadband state
// live in the state stage, so each
// item sees the state left by the previous one with no stall. Every stage advances
// independently, so bubbles are squeezed out and s_tready only drops when all four
// stages are full and m_tready is low. Configuration is taken at any time on the
// cfg channel (cfg_ready is always high) but must only change while the block is idle.
// kind travels in s_tuser: 0 control sample, 1 load integral, 2 raise integral.

module pid_with_hysteresis_deadband_top #(
  parameter int SAMPLE_WIDTH   = pwhd_pkg::SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pwhd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // kind[1:0]
  input  wire [pwhd_pkg::KIND_W-1:0]            s_tuser,
  // target[SW-1:0], measured[2*SW-1:SW], preset_value[2*SW+31:2*SW], zero fill to bytes
  input  wire [((2*SAMPLE_WIDTH+32+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // drive[31:0], integral[63:32], stable[64], zero fill [71:65]
  output logic [71:0]                           m_tdata,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [pwhd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  wire [pwhd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pwhd_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  // configuration registers
  pwhd_cfg_t cfg;

  // input register
  logic                 v0;
  kind_t                in_kind;
  logic signed [SW-1:0] in_target;
  logic signed [SW-1:0] in_measured;
  logic signed [31:0]   in_preset;

  // stage valids: state, multiply, output
  logic v1;
  logic v2;
  logic v3;

  // per-stage move/space signals
  logic go1, go2, go3;
  logic mv0, mv1, mv2;

  logic                 st_compute;
  logic signed [SW:0]   st_err;
  logic signed [SW+1:0] st_derr;
  logic signed [31:0]   st_integral;
  logic                 st_stable;

  logic                  mu_compute;
  logic signed [SW+16:0] mu_p;
  logic signed [47:0]    mu_i;
  logic signed [SW+17:0] mu_d;
  logic signed [31:0]    mu_integral;
  logic                  mu_stable;

  logic signed [31:0] held_drive;
  logic signed [31:0] out_integral;
  logic               out_stable;

  // a stage has room when empty or when its content leaves this cycle
  assign go3      = !v3 || m_tready;
  assign mv2      = v2 && go3;
  assign go2      = !v2 || go3;
  assign mv1      = v1 && go2;
  assign go1      = !v1 || go2;
  assign mv0      = v0 && go1;
  assign s_tready = !v0 || go1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_addr))
        REG_GAIN_P:     cfg.gain_p             <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:     cfg.gain_i             <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:     cfg.gain_d             <= cfg_data[GAIN_W-1:0];
        REG_INT_LIMIT:  cfg.integral_limit     <= cfg_data[LIMIT_W-1:0];
        REG_OUT_LIMIT:  cfg.output_limit       <= cfg_data[LIMIT_W-1:0];
        REG_DB_THRESH:  cfg.deadband_threshold <= cfg_data[THR_W-1:0];
        REG_LOOP_EN:    cfg.loop_enable        <= cfg_data[0];
        REG_AUTO_CLEAR: cfg.auto_clear         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_tready) v0 <= s_tvalid;
      if (go1)      v1 <= mv0;
      if (go2)      v2 <= mv1;
      if (go3)      v3 <= mv2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind     <= kind_t'(s_tuser);
      in_target   <= s_tdata[SW-1:0];
      in_measured <= s_tdata[2*SW-1:SW];
      in_preset   <= s_tdata[2*SW+31:2*SW];
    end
  end

  pwhd_state #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_state (
    .clk          (clk),
    .rst          (rst),
    .advance      (mv0),
    .cfg          (cfg),
    .kind         (in_kind),
    .target       (in_target),
    .measured     (in_measured),
    .preset_value (in_preset),
    .st_compute   (st_compute),
    .st_err       (st_err),
    .st_derr      (st_derr),
    .st_integral  (st_integral),
    .st_stable    (st_stable)
  );

  pwhd_mult #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mult (
    .clk         (clk),
    .advance     (mv1),
    .cfg         (cfg),
    .st_compute  (st_compute),
    .st_err      (st_err),
    .st_derr     (st_derr),
    .st_integral (st_integral),
    .st_stable   (st_stable),
    .mu_compute  (mu_compute),
    .mu_p        (mu_p),
    .mu_i        (mu_i),
    .mu_d        (mu_d),
    .mu_integral (mu_integral),
    .mu_stable   (mu_stable)
  );

  pwhd_out #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .advance      (mv2),
    .cfg          (cfg),
    .mu_compute   (mu_compute),
    .mu_p         (mu_p),
    .mu_i         (mu_i),
    .mu_d         (mu_d),
    .mu_integral  (mu_integral),
    .mu_stable    (mu_stable),
    .held_drive   (held_drive),
    .out_integral (out_integral),
    .out_stable   (out_stable)
  );

  // held_drive only changes when an item enters the output register, so it is the payload
  assign m_tvalid = v3;
  assign m_tdata  = {7'b0, out_stable, out_integral, held_drive};

  // input may only stall when every stage holds an item
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v0 && v1 && v2 && v3))
    else $error("input stalled while the pipeline has an empty stage");

  // an item leaving the input register always lands in the state stage
  a_state_stage_fill: assert property (@(posedge clk) disable iff (rst)
    mv0 |=> v1)
    else $error("item lost between input and state stage");

  // an output transfer with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !v2) |=> !m_tvalid)
    else $error("output valid without a new item");

endmodule

`default_nettype wire
